// ===== rtl/acps_pkg.sv =====
package acps_pkg;

   localparam int NUM_CELLS_DEF = 256;
   localparam int COORD_W       = 24;
   localparam int INDEX_W       = 8;
   localparam int LIMIT_W       = 40;
   localparam int CENT_W        = 3 * COORD_W;
   localparam int SQ_W          = 2 * COORD_W;
   localparam int SUM_W         = SQ_W + 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } acps_state_type;

endpackage

// ===== rtl/active_cell_proximity_search.sv =====
// Proximity search over a table of NUM_CELLS cell centres with active flags.
// Request channel (req_*): one item either writes a cell (kind 0: centre and
// active flag at cell_index; an index of NUM_CELLS or more is dropped) or
// queries a point (kind 1). A write produces no response; a query produces
// one response item whose inside_hit is set if some active cell lies within
// the squared radius held in the csr register (sixteen fraction bits).
// A write leaves the request side free, so the next item can be accepted
// in the next cycle. A query scans the table one cell per cycle through a
// single distance unit (table read, abs difference and square registers,
// then a combinational sum and compare); its response is loaded once the
// scan ends and the unit is empty; the request side stalls in scan and drain.
// The response sits in an output register: new writes and queries are taken
// while it waits; a finished query holds in drain while an earlier response
// still waits and rsp_stall is high. Reset starts a sweep over all NUM_CELLS
// cells that clears every active flag; req_stall stays high during the sweep.
// csr writes are taken at any time and restore to a limit of 4.0 on reset.
module active_cell_proximity_search #(
   parameter int NUM_CELLS = acps_pkg::NUM_CELLS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [acps_pkg::INDEX_W-1:0]           req_cell_index,
   input  logic                                   req_cell_active,
   input  logic signed [acps_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [acps_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [acps_pkg::COORD_W-1:0]    req_coord_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_inside_hit,
   input  logic                                   csr_wr_en,
   input  logic [acps_pkg::LIMIT_W-1:0]           csr_wr_data
);
   import acps_pkg::*;

   localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NUM_CELLS - 1);

   logic [CENT_W-1:0] cent_mem [NUM_CELLS];
   logic              act_mem  [NUM_CELLS];

   acps_state_type state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;

   logic              rd_vld_ff, rd_vld_in;
   logic              act_rd_ff;
   logic [CENT_W-1:0] cent_rd_ff;

   logic               mag_vld_ff, mag_vld_in;
   logic               mag_act_ff, mag_act_in;
   logic [COORD_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [COORD_W-1:0] mag_x_in, mag_y_in, mag_z_in;

   logic            sq_vld_ff, sq_vld_in;
   logic            sq_act_ff, sq_act_in;
   logic [SQ_W-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0] sq_x_in, sq_y_in, sq_z_in;

   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;

   logic [ADDR_W+INDEX_W-1:0] idx_ext;
   logic [ADDR_W-1:0]         wr_addr;
   logic                      idx_ok;
   logic                      act_we, act_wdata, cent_we;
   logic [ADDR_W-1:0]         act_waddr;
   logic                      point_load, scan_rd, rsp_load, pipe_busy;
   logic [SUM_W-1:0]          dist_sum;
   logic                      hit;

   assign idx_ext   = (ADDR_W + INDEX_W)'(req_cell_index);
   assign wr_addr   = idx_ext[ADDR_W-1:0];
   assign idx_ok    = 32'(req_cell_index) < NUM_CELLS;
   assign pipe_busy = rd_vld_ff | mag_vld_ff | sq_vld_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_stall  = 1'b1;
      act_we     = 1'b0;
      act_waddr  = wr_addr;
      act_wdata  = req_cell_active;
      cent_we    = 1'b0;
      point_load = 1'b0;
      scan_rd    = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            act_we    = 1'b1;
            act_waddr = cnt_ff;
            act_wdata = 1'b0;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == KIND_QUERY) begin
                  point_load = 1'b1;
                  cnt_in     = '0;
                  state_in   = ST_SCAN;
               end else if (idx_ok) begin
                  act_we  = 1'b1;
                  cent_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            scan_rd = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy && (!rsp_valid_ff || !rsp_stall)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // cell table
   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_rd_ff <= act_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (cent_we) begin
         cent_mem[wr_addr] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      cent_rd_ff <= cent_mem[cnt_ff];
   end

   // distance unit
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] d_neg;
      d     = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      d_neg = -d;
      return d[COORD_W] ? d_neg[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   assign rd_vld_in  = scan_rd;
   assign mag_vld_in = rd_vld_ff;
   assign mag_act_in = act_rd_ff;
   assign mag_x_in   = abs_diff(pt_x_ff, cent_rd_ff[COORD_W-1:0]);
   assign mag_y_in   = abs_diff(pt_y_ff, cent_rd_ff[2*COORD_W-1:COORD_W]);
   assign mag_z_in   = abs_diff(pt_z_ff, cent_rd_ff[3*COORD_W-1:2*COORD_W]);

   assign sq_vld_in = mag_vld_ff;
   assign sq_act_in = mag_act_ff;
   assign sq_x_in   = SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
   assign sq_y_in   = SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
   assign sq_z_in   = SQ_W'(mag_z_ff) * SQ_W'(mag_z_ff);

   assign dist_sum = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign hit      = sq_vld_ff & sq_act_ff & (dist_sum <= SUM_W'(limit_ff));
   assign found_in = point_load ? 1'b0 : (found_ff | hit);

   assign limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   assign rsp_hit_in   = rsp_load ? found_ff : rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rd_vld_ff    <= 1'b0;
         mag_vld_ff   <= 1'b0;
         sq_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         rd_vld_ff    <= rd_vld_in;
         mag_vld_ff   <= mag_vld_in;
         sq_vld_ff    <= sq_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (point_load) begin
         pt_x_ff <= req_coord_x;
         pt_y_ff <= req_coord_y;
         pt_z_ff <= req_coord_z;
      end
      mag_act_ff <= mag_act_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      mag_z_ff   <= mag_z_in;
      sq_act_ff  <= sq_act_in;
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
      sq_z_ff    <= sq_z_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_hit = rsp_hit_ff;

   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("response raised outside drain");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance pipeline busy outside a query");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rd_vld_ff && !mag_vld_ff && !sq_vld_ff)
      else $error("response loaded with cells still in flight");

   a_found_cleared: assert property (@(posedge clock) disable iff (reset)
      point_load |=> !found_ff)
      else $error("hit flag not cleared at query start");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import acps_pkg::*;

   localparam int NUM_CELLS = NUM_CELLS_DEF;
   localparam int SETTLE_CYCLES = NUM_CELLS + 8;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = KIND_WRITE;
   logic [INDEX_W-1:0] req_cell_index = '0;
   logic req_cell_active = 1'b0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_hit;
   logic csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   logic signed [COORD_W-1:0] centre_x [NUM_CELLS];
   logic signed [COORD_W-1:0] centre_y [NUM_CELLS];
   logic signed [COORD_W-1:0] centre_z [NUM_CELLS];
   bit cell_on [NUM_CELLS];
   logic [LIMIT_W-1:0] radius_sq_limit = LIMIT_RESET;
   bit hit_queue [$];
   int written_cells [$];

   bit idle_en = 1'b1;
   int stall_left = 0;
   int fail_count = 0;
   int cycle_count = 0;
   bit expected_hit;

   active_cell_proximity_search #(
      .NUM_CELLS(NUM_CELLS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_cell_index(req_cell_index),
      .req_cell_active(req_cell_active),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_inside_hit(rsp_inside_hit),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         centre_x[i] = '0;
         centre_y[i] = '0;
         centre_z[i] = '0;
         cell_on[i] = 1'b0;
      end
   end

   function automatic bit predict_hit(input logic signed [COORD_W-1:0] px, py, pz);
      longint dx;
      longint dy;
      longint dz;
      longint dist_sq;
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (cell_on[i]) begin
            dx = longint'(px) - longint'(centre_x[i]);
            dy = longint'(py) - longint'(centre_y[i]);
            dz = longint'(pz) - longint'(centre_z[i]);
            dist_sq = dx * dx + dy * dy + dz * dz;
            if (dist_sq <= longint'({24'd0, radius_sq_limit}))
               hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return COORD_W'(int'($urandom_range(0, 4095)) - 2048);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] near_coord(
      input logic signed [COORD_W-1:0] base, input int unsigned reach);
      int unsigned d;
      d = $urandom_range(0, reach);
      if ($urandom_range(0, 1))
         return COORD_W'(base + d);
      return COORD_W'(base - d);
   endfunction

   // hold the item until accepted, then update the cell table or queue the expected hit
   task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                            input logic act, input logic signed [COORD_W-1:0] x, y, z);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_cell_index <= idx;
      req_cell_active <= act;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_WRITE) begin
         centre_x[idx] = x;
         centre_y[idx] = y;
         centre_z[idx] = z;
         cell_on[idx] = act;
         if (act)
            written_cells.push_back(int'(idx));
      end else begin
         hit_queue.push_back(predict_hit(x, y, z));
      end
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      radius_sq_limit = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_empty_table();
      send_item(KIND_QUERY, 8'd0, 1'b1, 24'sd0, 24'sd0, 24'sd0);
   endtask

   task automatic test_radius_boundary();
      send_item(KIND_WRITE, 8'd0, 1'b1, 24'sd0, 24'sd0, 24'sd0);
      send_item(KIND_QUERY, 8'd0, 1'b0, 24'sd512, 24'sd0, 24'sd0);
      send_item(KIND_QUERY, 8'd0, 1'b0, 24'sd513, 24'sd0, 24'sd0);
      send_item(KIND_QUERY, 8'd0, 1'b0, 24'sd256, 24'sd256, 24'sd256);
      send_item(KIND_QUERY, 8'd0, 1'b0, -24'sd512, 24'sd0, 24'sd0);
   endtask

   task automatic test_inactive_cell();
      send_item(KIND_WRITE, 8'd0, 1'b0, 24'sd0, 24'sd0, 24'sd0);
      send_item(KIND_QUERY, 8'd0, 1'b1, 24'sd0, 24'sd0, 24'sd0);
   endtask

   task automatic test_coord_extremes();
      send_item(KIND_WRITE, 8'd255, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
      send_item(KIND_QUERY, 8'd255, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
      send_item(KIND_QUERY, 8'd255, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(KIND_WRITE, 8'd255, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(KIND_QUERY, 8'd0, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(KIND_WRITE, 8'd255, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
   endtask

   task automatic test_limit_extremes();
      write_limit('0);
      send_item(KIND_WRITE, 8'd1, 1'b1, 24'sd1000, -24'sd1000, 24'sd5);
      send_item(KIND_QUERY, 8'd0, 1'b0, 24'sd1000, -24'sd1000, 24'sd5);
      send_item(KIND_QUERY, 8'd0, 1'b0, 24'sd1001, -24'sd1000, 24'sd5);
      write_limit(LIMIT_MAX);
      send_item(KIND_WRITE, 8'd2, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(KIND_QUERY, 8'd0, 1'b0, COORD_MIN + 24'sd1048575, COORD_MIN, COORD_MIN);
      send_item(KIND_QUERY, 8'd0, 1'b0, COORD_MIN + 24'sd1048576, COORD_MIN, COORD_MIN);
      send_item(KIND_WRITE, 8'd1, 1'b0, 24'sd0, 24'sd0, 24'sd0);
      send_item(KIND_WRITE, 8'd2, 1'b0, 24'sd0, 24'sd0, 24'sd0);
   endtask

   task automatic test_random_traffic();
      logic [INDEX_W-1:0] slot;
      int base_cell;
      int unsigned reach;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_limit(LIMIT_RESET);
            1: write_limit('0);
            2: write_limit(LIMIT_MAX);
            3: write_limit(LIMIT_W'($urandom_range(0, 1 << 22)));
            4: write_limit({8'($urandom), 32'($urandom)});
            default: write_limit(LIMIT_W'($urandom_range(100000, 600000)));
         endcase
         idle_en = (phase != 2 && phase != 5);
         repeat (225) begin
            if ($urandom_range(0, 99) < 55) begin
               slot = INDEX_W'($urandom);
               send_item(KIND_WRITE, slot, $urandom_range(0, 3) != 0,
                         rand_coord(), rand_coord(), rand_coord());
            end else if (written_cells.size() != 0 && $urandom_range(0, 9) < 7) begin
               base_cell = written_cells[$urandom_range(0, written_cells.size() - 1)];
               case ($urandom_range(0, 3))
                  0: reach = 0;
                  1: reach = 2;
                  2: reach = 700;
                  default: reach = 1 << 20;
               endcase
               send_item(KIND_QUERY, INDEX_W'($urandom), 1'($urandom_range(0, 1)),
                         near_coord(centre_x[base_cell], reach),
                         near_coord(centre_y[base_cell], reach),
                         near_coord(centre_z[base_cell], reach));
            end else begin
               send_item(KIND_QUERY, INDEX_W'($urandom), 1'($urandom_range(0, 1)),
                         rand_coord(), rand_coord(), rand_coord());
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected item, inside_hit %0b", $time, rsp_inside_hit);
            fail_count++;
         end else begin
            expected_hit = hit_queue.pop_front();
            if (rsp_inside_hit !== expected_hit) begin
               $display("%0t: inside_hit expected %0b actual %0b",
                        $time, expected_hit, rsp_inside_hit);
               fail_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_radius_boundary();
      test_inactive_cell();
      test_coord_extremes();
      test_limit_extremes();
      test_random_traffic();
      drain_block();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
